[src/bwn_pkg.sv]
// ----------------------------------------------------------------------------
// bwn_pkg: shared types and constants for the boundary winding number block
// Widths of the count and result fields, saturation limits, the per-pair
// count step type and the beat that passes from the pair stage to the count.
// ----------------------------------------------------------------------------
package bwn_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int CFG_W = 8;
  localparam int HALF_W = 15;
  localparam int WIND_W = 14;
  localparam int CLAMP_W = 18;

  // Largest winding magnitude the block reports before the field range clamp.
  localparam int MAX_POINTS = 4096;

  localparam logic signed [HALF_W:0] HALF_MAX = 16'sd16383;
  localparam logic signed [HALF_W:0] HALF_MIN = -16'sd16384;
  localparam logic signed [CLAMP_W-1:0] POINTS_MAX = CLAMP_W'(MAX_POINTS);
  localparam logic signed [CLAMP_W-1:0] POINTS_MIN = -CLAMP_W'(MAX_POINTS);
  localparam logic signed [CLAMP_W-1:0] WIND_MAX = 18'sd8191;
  localparam logic signed [CLAMP_W-1:0] WIND_MIN = -18'sd8192;

  // Count step of one sample pair, in units of one half turn.
  typedef logic signed [2:0] delta_t;

  localparam delta_t DELTA_NONE = 3'sd0;
  localparam delta_t DELTA_HALF_POS = 3'sd1;
  localparam delta_t DELTA_HALF_NEG = -3'sd1;
  localparam delta_t DELTA_FULL_POS = 3'sd2;
  localparam delta_t DELTA_FULL_NEG = -3'sd2;

  typedef struct packed {
    delta_t d_step;   // pair (previous, current)
    delta_t d_close;  // closing pair (current, first), last sample only
    logic   last;
  } pair_beat_t;

endpackage

[src/bwn_if.sv]
// ----------------------------------------------------------------------------
// bwn interfaces: valid/ready channels of the boundary winding number block
// Sample stream, winding result stream and the band configuration write.
// ----------------------------------------------------------------------------
interface bwn_sample_if import bwn_pkg::*; #(parameter int W = SAMPLE_BITS_DEF);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] re;
  logic signed [W-1:0] im;
  logic                last;

  modport source (output valid, output re, output im, output last, input ready);
  modport sink (input valid, input re, input im, input last, output ready);
endinterface

interface bwn_winding_if import bwn_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [WIND_W-1:0] winding;

  modport source (output valid, output winding, input ready);
  modport sink (input valid, input winding, output ready);
endinterface

interface bwn_cfg_if import bwn_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/bwn_pair_test.sv]
// ----------------------------------------------------------------------------
// bwn_pair_test: negative real axis crossing test for one sample pair
// Gives the count step of the pair (a, b) in half turns.
// ----------------------------------------------------------------------------
module bwn_pair_test import bwn_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic signed [W-1:0] a_re,
  input  logic signed [W-1:0] a_im,
  input  logic signed [W-1:0] b_re,
  input  logic signed [W-1:0] b_im,
  input  logic [CFG_W-1:0]    band,
  output delta_t              delta
);

  logic                  a_neg;
  logic                  b_neg;
  logic signed [2*W-1:0] p1;
  logic signed [2*W-1:0] p2;
  logic signed [W:0]     a_ext;
  logic signed [W:0]     b_ext;
  logic [W:0]            a_mag;
  logic [W:0]            b_mag;
  logic [W:0]            band_ext;
  logic                  a_on;
  logic                  b_on;

  assign a_neg = a_im[W-1];
  assign b_neg = b_im[W-1];
  assign p1 = a_im * b_re;
  assign p2 = a_re * b_im;

  assign a_ext = {a_im[W-1], a_im};
  assign b_ext = {b_im[W-1], b_im};
  assign a_mag = a_ext[W] ? $unsigned(-a_ext) : $unsigned(a_ext);
  assign b_mag = b_ext[W] ? $unsigned(-b_ext) : $unsigned(b_ext);
  assign band_ext = {{(W + 1 - CFG_W){1'b0}}, band};
  assign a_on = (a_mag <= band_ext);
  assign b_on = (b_mag <= band_ext);

  always_comb begin
    delta = DELTA_NONE;
    if (a_neg != b_neg) begin
      // With the signs apart, a.im > b.im exactly when b is the negative one.
      if ((p1 != p2) && ((p1 > p2) != b_neg)) begin
        delta = a_neg ? DELTA_FULL_NEG : DELTA_FULL_POS;
      end
    end else if (a_on && a_re[W-1]) begin
      delta = b_neg ? DELTA_HALF_POS : DELTA_HALF_NEG;
    end else if (b_on && b_re[W-1]) begin
      delta = a_neg ? DELTA_HALF_NEG : DELTA_HALF_POS;
    end
  end

endmodule

[src/bwn_pair_stage.sv]
// ----------------------------------------------------------------------------
// bwn_pair_stage: input register, loop tracking and pair tests
// Holds the first and previous samples of the loop and registers the count
// steps of the two pairs that each sample closes.
// ----------------------------------------------------------------------------
module bwn_pair_stage import bwn_pkg::*; #(
  parameter int W = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  bwn_sample_if.sink       smp,
  input  logic [CFG_W-1:0] axis_band,
  output logic             beat_valid,
  output pair_beat_t       beat,
  input  logic             beat_ready
);

  logic                s1_valid;
  logic signed [W-1:0] s1_re;
  logic signed [W-1:0] s1_im;
  logic                s1_last;
  logic signed [W-1:0] first_re;
  logic signed [W-1:0] first_im;
  logic signed [W-1:0] prev_re;
  logic signed [W-1:0] prev_im;
  logic                in_loop;
  logic signed [W-1:0] close_re;
  logic signed [W-1:0] close_im;
  delta_t              step_delta;
  delta_t              close_delta;
  logic                s1_fire;
  logic                s2_free;

  assign s2_free = !beat_valid || beat_ready;
  assign s1_fire = s1_valid && s2_free;
  assign smp.ready = !s1_valid || s1_fire;

  // A loop of one sample closes on itself.
  assign close_re = in_loop ? first_re : s1_re;
  assign close_im = in_loop ? first_im : s1_im;

  bwn_pair_test #(.W(W)) u_step (
    .a_re(prev_re), .a_im(prev_im), .b_re(s1_re), .b_im(s1_im),
    .band(axis_band), .delta(step_delta)
  );

  bwn_pair_test #(.W(W)) u_close (
    .a_re(s1_re), .a_im(s1_im), .b_re(close_re), .b_im(close_im),
    .band(axis_band), .delta(close_delta)
  );

  always_ff @(posedge clk) begin
    if (smp.valid && smp.ready) begin
      s1_re <= smp.re;
      s1_im <= smp.im;
      s1_last <= smp.last;
    end
    if (s1_fire) begin
      beat.d_step <= in_loop ? step_delta : DELTA_NONE;
      beat.d_close <= s1_last ? close_delta : DELTA_NONE;
      beat.last <= s1_last;
    end
    if (rst) begin
      s1_valid <= 1'b0;
      beat_valid <= 1'b0;
      in_loop <= 1'b0;
      prev_re <= '0;
      prev_im <= '0;
      first_re <= '0;
      first_im <= '0;
    end else begin
      if (smp.valid && smp.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        beat_valid <= 1'b1;
        in_loop <= !s1_last;
        prev_re <= s1_re;
        prev_im <= s1_im;
        if (!in_loop) begin
          first_re <= s1_re;
          first_im <= s1_im;
        end
      end else if (beat_ready) begin
        beat_valid <= 1'b0;
      end
    end
  end

endmodule

[src/bwn_count_stage.sv]
// ----------------------------------------------------------------------------
// bwn_count_stage: saturating half count, rounding and result register
// Adds the two pair steps of each beat and emits the rounded winding number
// on the last sample of a loop.
// ----------------------------------------------------------------------------
module bwn_count_stage import bwn_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          beat_valid,
  input  pair_beat_t    beat,
  output logic          beat_ready,
  bwn_winding_if.source res
);

  logic signed [HALF_W-1:0]  half_count;
  logic signed [HALF_W-1:0]  half_mid;
  logic signed [HALF_W-1:0]  half_next;
  logic signed [HALF_W:0]    half_wide;
  logic signed [HALF_W:0]    rounded;
  logic signed [CLAMP_W-1:0] w_ext;
  logic signed [CLAMP_W-1:0] w_pts;
  logic signed [CLAMP_W-1:0] w_fin;
  logic                      take;

  function automatic logic signed [HALF_W-1:0] sat_add(
    input logic signed [HALF_W-1:0] h,
    input delta_t d
  );
    logic signed [HALF_W:0] s;
    s = (HALF_W + 1)'(h) + (HALF_W + 1)'(d);
    if (s > HALF_MAX) begin
      s = HALF_MAX;
    end else if (s < HALF_MIN) begin
      s = HALF_MIN;
    end
    return s[HALF_W-1:0];
  endfunction

  assign half_mid = sat_add(half_count, beat.d_step);
  assign half_next = sat_add(half_mid, beat.d_close);

  // Round half away from zero.
  assign half_wide = (HALF_W + 1)'(half_next);
  assign rounded = half_wide[HALF_W] ? -((-half_wide + 16'sd1) >>> 1)
                                     : ((half_wide + 16'sd1) >>> 1);

  always_comb begin
    w_ext = CLAMP_W'(rounded);
    w_pts = w_ext;
    if (w_ext > POINTS_MAX) begin
      w_pts = POINTS_MAX;
    end else if (w_ext < POINTS_MIN) begin
      w_pts = POINTS_MIN;
    end
    w_fin = w_pts;
    if (w_pts > WIND_MAX) begin
      w_fin = WIND_MAX;
    end else if (w_pts < WIND_MIN) begin
      w_fin = WIND_MIN;
    end
  end

  // A beat without a result never waits on the output side.
  assign take = beat_valid && (!beat.last || !res.valid || res.ready);
  assign beat_ready = take;

  always_ff @(posedge clk) begin
    if (take && beat.last) begin
      res.winding <= w_fin[WIND_W-1:0];
    end
    if (rst) begin
      half_count <= '0;
      res.valid <= 1'b0;
    end else begin
      if (take) begin
        half_count <= beat.last ? '0 : half_next;
      end
      if (take && beat.last) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

endmodule

[src/boundary_winding_number.sv]
// ----------------------------------------------------------------------------
// boundary_winding_number: winding number of a sampled closed boundary
// Counts signed crossings of the negative real axis by a stream of complex
// samples and reports the rounded winding number at the end of each loop.
// ----------------------------------------------------------------------------
// Usage. Samples arrive on the smp channel as (re, im, last) beats, in order
// around the boundary; last marks the final sample of a loop, and the next
// beat starts a new loop. Each loop yields one beat on the res channel,
// carrying the winding number rounded half away from zero; other samples
// yield nothing. The cfg channel writes axis_band, the on-axis tolerance;
// it is always ready and should be written only while no loop is in flight.
// Throughput is one sample per cycle. A sample passes an input register,
// the pair test (two multipliers and a compare) into a step register, and
// the saturating count into the result register. When the receiver stalls,
// the result register holds its beat; samples that carry no result keep
// flowing, and the next last sample waits in the step register, which in
// turn holds back the input register and then smp.ready.
// Reset clears all valid flags, the loop state, the count and axis_band.
// ----------------------------------------------------------------------------
module boundary_winding_number import bwn_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bwn_sample_if.sink    smp,
  bwn_cfg_if.sink       cfg,
  bwn_winding_if.source res
);

  // On-axis band; taken on every configuration beat.
  logic [CFG_W-1:0] axis_band;

  // Count steps passed from the pair stage to the count stage.
  logic       beat_valid;
  logic       beat_ready;
  pair_beat_t beat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_band <= '0;
    end else if (cfg.valid) begin
      axis_band <= cfg.data;
    end
  end

  // Tracks first and previous samples and tests both pairs of each sample.
  bwn_pair_stage #(.W(SAMPLE_BITS)) u_pair (
    .clk        (clk),
    .rst        (rst),
    .smp        (smp),
    .axis_band  (axis_band),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  // Accumulates half turns and rounds at the end of each loop.
  bwn_count_stage u_count (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_ready (beat_ready),
    .res        (res)
  );

endmodule
